### hdl/abq_pkg.sv
package abq_pkg;

  localparam logic [1:0] KIND_RECV  = 2'd0;
  localparam logic [1:0] KIND_SEND  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_ATTEMPTS = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
  localparam logic [7:0]  ATTEMPTS_RESET = 8'd8;
  localparam logic [4:0]  MAX_RESULTS    = 5'd16;

  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_CTRL_DROP  = 4'd1;
  localparam logic [3:0] ACT_OUT_SYNC   = 4'd2;
  localparam logic [3:0] ACT_NEW_CLIENT = 4'd3;
  localparam logic [3:0] ACT_DELIVER    = 4'd4;
  localparam logic [3:0] ACT_SEND_ACKED = 4'd5;
  localparam logic [3:0] ACT_STALE_ACK  = 4'd6;
  localparam logic [3:0] ACT_DISC_IGN   = 4'd7;
  localparam logic [3:0] ACT_TRANSMIT   = 4'd8;
  localparam logic [3:0] ACT_RETRANSMIT = 4'd9;
  localparam logic [3:0] ACT_SEND_FAIL  = 4'd10;
  localparam logic [3:0] ACT_TABLE_FULL = 4'd11;
  localparam logic [3:0] ACT_REFUSED    = 4'd12;
  localparam logic [3:0] ACT_CLOSED     = 4'd13;
  localparam logic [3:0] ACT_CLOSE_UNK  = 4'd14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ACT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] ip;
    logic        recv_sync;
    logic        send_sync;
    logic [7:0]  attempts;
    logic [15:0] time_left;
  } entry_t;

  typedef struct packed {
    logic mem_we;
    logic flag_we;
    logic valid;
    logic pending;
  } tbl_wr_t;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] slot;
    logic       send_ack;
    logic       ack_sync;
    logic       deliver;
    logic       transmit;
    logic       tx_sync;
    logic       last;
  } res_t;

endpackage

### hdl/abq_table.sv
module abq_table
  import abq_pkg::*;
#(
  parameter int CLIENTS = 16,
  parameter int IW = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [IW-1:0]      rd_addr,
  output entry_t             rd_data,
  input  tbl_wr_t            wr,
  input  logic [IW-1:0]      wr_addr,
  input  entry_t             wr_data,
  output logic [CLIENTS-1:0] valid,
  output logic [CLIENTS-1:0] pending
);

  entry_t mem [CLIENTS];

  // client entries: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      pending <= '0;
    end else if (wr.flag_we) begin
      valid[wr_addr]   <= wr.valid;
      pending[wr_addr] <= wr.pending;
    end
  end

endmodule

### hdl/alternating_bit_arq_client_table_core.sv
// Channel   Handshake              Payload
// item in   start high, busy low   kind, client_port, client_ip, is_ack,
//                                  is_disconnect, sync_bit
// result    done high, one cycle   action, slot, send_ack, ack_sync, deliver,
//                                  transmit, tx_sync, last
// config    cfg_we high            cfg_index, cfg_data
//
// Every item walks the client table once, each slot read (ST_READ), then compared
// or updated (ST_EVAL) in the shared unit; a new item is accepted only once the
// sequencer is back in ST_IDLE. Packets, sends and closes give one result,
// registered in ST_ACT after the last slot is compared; a tick gives up to 16
// results, at most one per slot, the final one marked and registered in ST_FLUSH
// after the walk. Reset is synchronous; it clears the valid and pending flags and
// the sequencer. Results cannot be stalled: each is shown for one cycle only.
module alternating_bit_arq_client_table_core
  import abq_pkg::*;
#(
  parameter int CLIENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [15:0] client_port,
  input  logic [31:0] client_ip,
  input  logic        is_ack,
  input  logic        is_disconnect,
  input  logic        sync_bit,
  output logic        done,
  output logic [3:0]  action,
  output logic [3:0]  slot,
  output logic        send_ack,
  output logic        ack_sync,
  output logic        deliver,
  output logic        transmit,
  output logic        tx_sync,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CLIENTS - 1);

  state_t state, state_next;

  logic [15:0] timeout;
  logic [7:0]  max_att;

  // latched item
  logic [1:0]  k_kind;
  logic [15:0] k_port;
  logic [31:0] k_ip;
  logic        k_ack, k_disc, k_sb;

  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] s_idx, s_idx_next, f_idx, f_idx_next;
  logic          found, found_next, free_found, free_found_next;
  entry_t        cap, cap_next;
  logic [4:0]    cnt, cnt_next;
  res_t          hold, hold_next;
  logic          hold_valid, hold_valid_next;
  res_t          res, res_next;
  logic          done_next;

  entry_t             rd_data, wr_data;
  tbl_wr_t            wr;
  logic [IW-1:0]      wr_addr;
  logic [CLIENTS-1:0] valid, pending;

  logic [15:0] reload;
  logic [7:0]  lim;
  logic        accept;
  res_t        r;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign reload = (timeout == 16'd0) ? 16'd1 : timeout;
  assign lim    = (max_att == 8'd0) ? 8'd1 : max_att;

  abq_table #(.CLIENTS(CLIENTS), .IW(IW)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .valid   (valid),
    .pending (pending)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
      max_att <= ATTEMPTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:  timeout <= cfg_data;
        REG_ATTEMPTS: max_att <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (idx == LAST_IDX) begin
          state_next = (k_kind == KIND_TICK) ? ST_FLUSH : ST_ACT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_ACT:   state_next = ST_IDLE;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_next        = idx;
    s_idx_next      = s_idx;
    f_idx_next      = f_idx;
    found_next      = found;
    free_found_next = free_found;
    cap_next        = cap;
    cnt_next        = cnt;
    hold_next       = hold;
    hold_valid_next = hold_valid;
    res_next        = res;
    done_next       = 1'b0;
    wr              = '0;
    wr_addr         = idx;
    wr_data         = rd_data;
    r               = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next        = '0;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          cnt_next        = '0;
          hold_valid_next = 1'b0;
        end
      end
      ST_READ: ;
      ST_EVAL: begin
        if (idx != LAST_IDX) begin
          idx_next = idx + 1'b1;
        end
        if (k_kind == KIND_TICK) begin
          if (valid[idx] && pending[idx]) begin
            wr.mem_we = 1'b1;
            if (rd_data.time_left > 16'd1) begin
              wr_data.time_left = rd_data.time_left - 16'd1;
            end else if (cnt == MAX_RESULTS) begin
              // out of result room: expire again on the next tick
              wr_data.time_left = 16'd1;
            end else begin
              cnt_next = cnt + 5'd1;
              r.slot   = 4'(idx);
              if (rd_data.attempts >= lim) begin
                wr.flag_we        = 1'b1;
                wr.valid          = 1'b1;
                wr.pending        = 1'b0;
                wr_data.time_left = 16'd0;
                r.action          = ACT_SEND_FAIL;
              end else begin
                wr_data.attempts  = rd_data.attempts + 8'd1;
                wr_data.time_left = reload;
                r.action          = ACT_RETRANSMIT;
                r.transmit        = 1'b1;
                r.tx_sync         = rd_data.send_sync;
              end
              // emit the previous result, hold this one until we know if it is final
              if (hold_valid) begin
                res_next  = hold;
                done_next = 1'b1;
              end
              hold_next       = r;
              hold_valid_next = 1'b1;
            end
          end
        end else begin
          if (valid[idx] && !found && rd_data.port == k_port && rd_data.ip == k_ip) begin
            found_next = 1'b1;
            s_idx_next = idx;
            cap_next   = rd_data;
          end
          if (!valid[idx] && !free_found) begin
            free_found_next = 1'b1;
            f_idx_next      = idx;
          end
        end
      end
      ST_ACT: begin
        r.last  = 1'b1;
        r.slot  = found ? 4'(s_idx) : 4'd0;
        wr_addr = s_idx;
        wr_data = cap;
        unique case (k_kind)
          KIND_RECV: begin
            if (!found) begin
              if (k_ack || k_disc) begin
                r.action = ACT_CTRL_DROP;
              end else if (k_sb) begin
                r.action   = ACT_OUT_SYNC;
                r.send_ack = 1'b1;
                r.ack_sync = 1'b1;
              end else if (!free_found) begin
                r.action   = ACT_TABLE_FULL;
                r.send_ack = 1'b1;
              end else begin
                wr.mem_we  = 1'b1;
                wr.flag_we = 1'b1;
                wr.valid   = 1'b1;
                wr.pending = 1'b0;
                wr_addr    = f_idx;
                wr_data    = '0;
                wr_data.port      = k_port;
                wr_data.ip        = k_ip;
                wr_data.send_sync = 1'b1;
                r.action   = ACT_NEW_CLIENT;
                r.slot     = 4'(f_idx);
                r.send_ack = 1'b1;
                r.deliver  = 1'b1;
              end
            end else if (k_disc) begin
              r.action = ACT_DISC_IGN;
            end else if (k_ack) begin
              if (pending[s_idx] && k_sb == cap.send_sync) begin
                wr.flag_we = 1'b1;
                wr.valid   = 1'b1;
                wr.pending = 1'b0;
                r.action   = ACT_SEND_ACKED;
              end else begin
                r.action = ACT_STALE_ACK;
              end
            end else begin
              r.send_ack = 1'b1;
              r.ack_sync = k_sb;
              if (k_sb == cap.recv_sync) begin
                r.action = ACT_OUT_SYNC;
              end else begin
                wr.mem_we         = 1'b1;
                wr_data.recv_sync = k_sb;
                r.action          = ACT_DELIVER;
                r.deliver         = 1'b1;
              end
            end
          end
          KIND_SEND: begin
            if (!found || pending[s_idx]) begin
              r.action = ACT_REFUSED;
            end else begin
              wr.mem_we         = 1'b1;
              wr.flag_we        = 1'b1;
              wr.valid          = 1'b1;
              wr.pending        = 1'b1;
              wr_data.send_sync = ~cap.send_sync;
              wr_data.attempts  = 8'd1;
              wr_data.time_left = reload;
              r.action          = ACT_TRANSMIT;
              r.transmit        = 1'b1;
              r.tx_sync         = ~cap.send_sync;
            end
          end
          default: begin
            if (!found) begin
              r.action = ACT_CLOSE_UNK;
            end else begin
              wr.flag_we = 1'b1;
              r.action   = ACT_CLOSED;
            end
          end
        endcase
        res_next  = r;
        done_next = 1'b1;
      end
      ST_FLUSH: begin
        if (hold_valid) begin
          res_next      = hold;
          res_next.last = 1'b1;
          done_next     = 1'b1;
        end
        hold_valid_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= done_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k_kind <= kind;
      k_port <= client_port;
      k_ip   <= client_ip;
      k_ack  <= is_ack;
      k_disc <= is_disconnect;
      k_sb   <= sync_bit;
    end
    idx        <= idx_next;
    s_idx      <= s_idx_next;
    f_idx      <= f_idx_next;
    found      <= found_next;
    free_found <= free_found_next;
    cap        <= cap_next;
    cnt        <= cnt_next;
    hold       <= hold_next;
    res        <= res_next;
  end

  assign action   = res.action;
  assign slot     = res.slot;
  assign send_ack = res.send_ack;
  assign ack_sync = res.ack_sync;
  assign deliver  = res.deliver;
  assign transmit = res.transmit;
  assign tx_sync  = res.tx_sync;
  assign last     = res.last;

endmodule
